// ----- hdl/wed_pkg.sv -----
// ----------------------------------------------------------------------------
// wed_pkg
// Shared types, constants and width helpers for the waveform envelope
// decimator: controller/datapath command and status groups, state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wed_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_IDX_W = 3;
  localparam int SAMPLE_W   = 32;
  localparam int LEVEL_W    = 32;
  localparam int CC_W       = 4;
  localparam int SPP_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int DEF_MAX_CHANNELS     = 8;
  localparam int DEF_MAX_POINT_FRAMES = 65536;

  localparam logic [CC_W-1:0]  CC_RESET   = 4'd2;
  localparam logic [SPP_W-1:0] SPP_RESET  = 17'd1024;
  localparam logic             MODE_RESET = 1'b0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH_MODE = 2'd2;

  function automatic int lane_cap(int max_ch);
    return (max_ch < NUM_LANES) ? max_ch : NUM_LANES;
  endfunction

  function automatic int frames_cap(int max_frames);
    int spp_max;
    spp_max = (1 << SPP_W) - 1;
    return (max_frames < spp_max) ? max_frames : spp_max;
  endfunction

  function automatic int count_width(int max_frames);
    return $clog2(frames_cap(max_frames) + 1);
  endfunction

  // A full point sums at most lanes * frames magnitudes of up to 2^31 each.
  function automatic int sum_width(int max_ch, int max_frames);
    return LEVEL_W + $clog2(lane_cap(max_ch) * frames_cap(max_frames));
  endfunction

  function automatic int div_width(int max_ch, int max_frames);
    return $clog2(lane_cap(max_ch) * frames_cap(max_frames) + 1);
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_LOAD,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  cap_frame;
    logic                  acc_lane;
    logic [LANE_IDX_W-1:0] lane_idx;
    logic                  count_inc;
    logic                  clear_all;
    logic                  div_load;
    logic                  div_step;
    logic                  emit;
    logic                  emit_flush;
  } cmd_t;

  typedef struct packed {
    logic last_lane;
    logic count_nz;
    logic point_full;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/wed_ctrl.sv -----
// ----------------------------------------------------------------------------
// wed_ctrl
// Sequencer: walks the active lanes of a frame, checks for a full point,
// runs the divider step count and hands the point to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wed_ctrl #(
  parameter int MAX_CHANNELS     = wed_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POINT_FRAMES = wed_pkg::DEF_MAX_POINT_FRAMES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             flush_i,
  output logic                  in_stall_o,
  input  wire wed_pkg::status_t status_i,
  output wed_pkg::cmd_t         cmd_o
);

  import wed_pkg::*;

  localparam int SumW    = sum_width(MAX_CHANNELS, MAX_POINT_FRAMES);
  localparam int DivCntW = $clog2(SumW);

  state_e state_q, state_d;
  logic [LANE_IDX_W-1:0] lane_q, lane_d;
  logic [DivCntW-1:0]    dcnt_q, dcnt_d;
  logic                  flush_q, flush_d;

  logic accept;
  logic div_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign div_last   = (dcnt_q == DivCntW'(SumW - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!flush_i) begin
            state_d = ST_ACCUM;
          end else if (status_i.count_nz) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_ACCUM: begin
        if (status_i.last_lane) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = status_i.point_full ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and counters.
  always_comb begin
    cmd_o            = '0;
    cmd_o.lane_idx   = lane_q;
    cmd_o.emit_flush = flush_q;
    lane_d           = lane_q;
    dcnt_d           = dcnt_q;
    flush_d          = flush_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!flush_i) begin
            cmd_o.cap_frame = 1'b1;
            lane_d          = '0;
            flush_d         = 1'b0;
          end else if (status_i.count_nz) begin
            flush_d = 1'b1;
          end else begin
            cmd_o.clear_all = 1'b1;
          end
        end
      end
      ST_ACCUM: begin
        cmd_o.acc_lane = 1'b1;
        lane_d         = lane_q + 1'b1;
        if (status_i.last_lane) begin
          cmd_o.count_inc = 1'b1;
        end
      end
      ST_CHECK: begin
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        dcnt_d         = '0;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = !status_i.out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
      dcnt_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      dcnt_q  <= dcnt_d;
      flush_q <= flush_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wed_dpath.sv -----
// ----------------------------------------------------------------------------
// wed_dpath
// Datapath: configuration registers, frame capture, magnitude accumulator,
// frame counter, restoring divider, running peak and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wed_dpath #(
  parameter int MAX_CHANNELS     = wed_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POINT_FRAMES = wed_pkg::DEF_MAX_POINT_FRAMES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wed_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [wed_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lanes_i [wed_pkg::NUM_LANES],
  input  wire wed_pkg::cmd_t                       cmd_i,
  output wed_pkg::status_t                         status_o,
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output logic [wed_pkg::LEVEL_W-1:0]              mean_level_o,
  output logic [wed_pkg::LEVEL_W-1:0]              peak_level_o,
  output logic                                     from_flush_o
);

  import wed_pkg::*;

  localparam int LaneCap   = lane_cap(MAX_CHANNELS);
  localparam int FramesMax = frames_cap(MAX_POINT_FRAMES);
  localparam int CountW    = count_width(MAX_POINT_FRAMES);
  localparam int SumW      = sum_width(MAX_CHANNELS, MAX_POINT_FRAMES);
  localparam int DivW      = div_width(MAX_CHANNELS, MAX_POINT_FRAMES);
  localparam int ProdW     = CC_W + CountW;

  logic [CC_W-1:0]  cc_q;
  logic [SPP_W-1:0] spp_q;
  logic             mode_q;

  logic [SAMPLE_W-1:0] lane_q [NUM_LANES];
  logic [SumW-1:0]     sum_q;
  logic [CountW-1:0]   count_q;
  logic [LEVEL_W-1:0]  peak_q;
  logic [SumW-1:0]     quo_q;
  logic [DivW-1:0]     rem_q;
  logic [DivW-1:0]     dsr_q;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  mean_out_q;
  logic [LEVEL_W-1:0]  peak_out_q;
  logic                flush_out_q;

  logic [CC_W-1:0]     chans;
  logic [SPP_W-1:0]    frames;
  logic [LEVEL_W-1:0]  mag;
  logic [ProdW-1:0]    prod;
  logic [DivW:0]       trial;
  logic                trial_ge;
  logic [LEVEL_W-1:0]  mean;
  logic [LEVEL_W-1:0]  peak_new;

  function automatic logic [LEVEL_W-1:0] magnitude(logic [SAMPLE_W-1:0] raw, logic wide);
    logic [SAMPLE_W-1:0] v32;
    logic [15:0]         v16;
    v32 = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    v16 = raw[15] ? (~raw[15:0] + 1'b1) : raw[15:0];
    return wide ? v32 : {v16, 16'd0};
  endfunction

  // Effective channel count and point length after clamping.
  always_comb begin
    chans = cc_q;
    if (chans == '0) begin
      chans = CC_W'(1);
    end
    if (chans > CC_W'(LaneCap)) begin
      chans = CC_W'(LaneCap);
    end
    frames = spp_q;
    if (frames == '0) begin
      frames = SPP_W'(1);
    end
    if (frames > SPP_W'(FramesMax)) begin
      frames = SPP_W'(FramesMax);
    end
  end

  assign mag      = magnitude(lane_q[cmd_i.lane_idx], mode_q);
  assign prod     = ProdW'(chans) * ProdW'(count_q);
  assign trial    = {rem_q, quo_q[SumW-1]};
  assign trial_ge = (trial >= {1'b0, dsr_q});
  assign mean     = quo_q[LEVEL_W-1:0];
  assign peak_new = (mean > peak_q) ? mean : peak_q;

  assign status_o.last_lane  = ({1'b0, cmd_i.lane_idx} == (chans - CC_W'(1)));
  assign status_o.count_nz   = (count_q != '0);
  assign status_o.point_full = (SPP_W'(count_q) >= frames);
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= CC_RESET;
      spp_q  <= SPP_RESET;
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT:     cc_q   <= cfg_data_i[CC_W-1:0];
        CFG_SAMPLES_PER_PIXEL: spp_q  <= cfg_data_i[SPP_W-1:0];
        CFG_SAMPLE_WIDTH_MODE: mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      peak_q  <= '0;
    end else begin
      if (cmd_i.acc_lane) begin
        sum_q <= sum_q + SumW'(mag);
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.clear_all) begin
        sum_q   <= '0;
        count_q <= '0;
        peak_q  <= '0;
      end
      if (cmd_i.emit) begin
        sum_q   <= '0;
        count_q <= '0;
        peak_q  <= cmd_i.emit_flush ? '0 : peak_new;
      end
    end
  end

  // Frame capture and divider registers hold payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_frame) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_q[i] <= lanes_i[i];
      end
    end
    if (cmd_i.div_load) begin
      quo_q <= sum_q;
      rem_q <= '0;
      dsr_q <= DivW'(prod);
    end else if (cmd_i.div_step) begin
      // One restoring step: the dividend shifts out at the top while the
      // quotient bits shift in at the bottom of the same register.
      quo_q <= {quo_q[SumW-2:0], trial_ge};
      rem_q <= trial_ge ? DivW'(trial - {1'b0, dsr_q}) : trial[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mean_out_q  <= mean;
      peak_out_q  <= peak_new;
      flush_out_q <= cmd_i.emit_flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_level_o = mean_out_q;
  assign peak_level_o = peak_out_q;
  assign from_flush_o = flush_out_q;

endmodule

`default_nettype wire

// ----- hdl/waveform_envelope_decimator.sv -----
// ----------------------------------------------------------------------------
// waveform_envelope_decimator
// Mean absolute value decimator for waveform display: sums lane magnitudes
// per frame and emits the mean and running peak once per point.
//
//   channel   direction  handshake             payload
//   in        request    in_valid_i/in_stall_o lane0..7_sample_i, flush_i
//   out       result     out_valid_o/out_stall_i mean_level_o, peak_level_o,
//                                                  from_flush_o
//   cfg       write      cfg_we_i              cfg_index_i, cfg_data_i
//
// Within a frame, one lane magnitude is added per cycle.
// A frame that completes a point, or a flush with frames pending, then
// runs the bit-serial divider before the result is emitted.
// A flush with nothing pending only clears sum, count and peak. No clearing pass after reset.
// The output register frees the datapath; a stalled result holds only the
// point that follows it, at its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_envelope_decimator #(
  parameter int MAX_CHANNELS     = wed_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POINT_FRAMES = wed_pkg::DEF_MAX_POINT_FRAMES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wed_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [wed_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane0_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane1_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane2_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane3_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane4_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane5_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane6_sample_i,
  input  wire logic signed [wed_pkg::SAMPLE_W-1:0] lane7_sample_i,
  input  wire logic                                flush_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [wed_pkg::LEVEL_W-1:0]              mean_level_o,
  output logic [wed_pkg::LEVEL_W-1:0]              peak_level_o,
  output logic                                     from_flush_o
);

  import wed_pkg::*;

  logic signed [SAMPLE_W-1:0] lanes [NUM_LANES];
  cmd_t    cmd;
  status_t status;

  assign lanes[0] = lane0_sample_i;
  assign lanes[1] = lane1_sample_i;
  assign lanes[2] = lane2_sample_i;
  assign lanes[3] = lane3_sample_i;
  assign lanes[4] = lane4_sample_i;
  assign lanes[5] = lane5_sample_i;
  assign lanes[6] = lane6_sample_i;
  assign lanes[7] = lane7_sample_i;

  wed_ctrl #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_POINT_FRAMES (MAX_POINT_FRAMES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flush_i    (flush_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wed_dpath #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_POINT_FRAMES (MAX_POINT_FRAMES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .lanes_i      (lanes),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .mean_level_o (mean_level_o),
    .peak_level_o (peak_level_o),
    .from_flush_o (from_flush_o)
  );

endmodule

`default_nettype wire
